>>> sv/assert_macros.svh
// Assertion macros shared by the edge list store RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> sv/delsu_pkg.sv
// Types and constants for the directed edge list store unit.
// No dependencies; used by every module of the block.
package delsu_pkg;

    localparam int VERT_W = 6;
    localparam int DEG_W  = 9;

    localparam logic [VERT_W-1:0] VC_RESET = 6'd32;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_ADJ    = 2'd1,
        FUNC_DEGREE = 2'd2,
        FUNC_LIST   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LIST,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [VERT_W-1:0] src;
        logic [VERT_W-1:0] dst;
    } edge_t;

    // Chain movement: shift_in pushes a new edge at cell 0 toward the tail,
    // rotate moves every entry one cell toward the head (tail refills from head).
    typedef struct packed {
        logic shift_in;
        logic rotate;
    } chain_ctrl_t;

endpackage

>>> sv/delsu_cell.sv
// One storage cell of the edge ring: holds one edge, takes a neighbor's edge.
// Depends on delsu_pkg.
module delsu_cell
(
    input  logic                 clk,
    input  delsu_pkg::chain_ctrl_t ctrl,
    input  delsu_pkg::edge_t     left_edge,
    input  delsu_pkg::edge_t     right_edge,
    output delsu_pkg::edge_t     edge_q
);

    delsu_pkg::edge_t data_reg;
    delsu_pkg::edge_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_in)
        begin
            data_next = left_edge;
        end
        else if (ctrl.rotate)
        begin
            data_next = right_edge;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign edge_q = data_reg;

endmodule

>>> sv/delsu_chain.sv
// Row of edge cells forming a ring; cell 0 is the head seen by the scanner.
// Depends on delsu_pkg and delsu_cell.
module delsu_chain
#(
    parameter int DEPTH = 128
)
(
    input  logic                   clk,
    input  delsu_pkg::chain_ctrl_t ctrl,
    input  delsu_pkg::edge_t       in_edge,
    output delsu_pkg::edge_t       head_edge
);

    delsu_pkg::edge_t q [DEPTH];

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        delsu_pkg::edge_t left_w;
        delsu_pkg::edge_t right_w;

        if (k == 0)
        begin : g_head
            assign left_w = in_edge;
        end
        else
        begin : g_body
            assign left_w = q[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_tail
            assign right_w = q[0];
        end
        else
        begin : g_inner
            assign right_w = q[k+1];
        end

        delsu_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .left_edge  (left_w),
            .right_edge (right_w),
            .edge_q     (q[k])
        );
    end

    assign head_edge = q[0];

endmodule

>>> sv/directed_edge_list_store_unit.sv
// Top level of the directed edge list store: control, scan, list and result.
// Depends on delsu_pkg, delsu_chain (delsu_cell) and assert_macros.svh.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | func, first_vertex, second_vertex
//  out      | out_valid / out_ready| status, is_adjacent, degree_count, neighbor,
//           |                      | neighbor_valid, last
//  cfg      | cfg_we               | cfg_wdata (vertex_count)
//
// Insert writes the ring on acceptance, then loads the result in S_EMIT. Other
// functions take one full turn of ring rotation (one stored edge passes the head
// cell per cycle); adjacency and degree then load the result in S_EMIT, and a
// listing walks candidates up from 1, one per cycle while the output is free,
// emitting each neighbor. Reset clears the edge count and restores vertex_count
// to 32; ring contents stay undefined and are never read beyond the count.
// No clearing pass. A stalled output holds S_EMIT and S_LIST in place; a new
// transaction is taken in idle even while a result waits in the output register.
`include "assert_macros.svh"

module directed_edge_list_store_unit
#(
    parameter int MAX_EDGES    = 128,
    parameter int MAX_VERTICES = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_we,
    input  logic [delsu_pkg::VERT_W-1:0] cfg_wdata,
    // input transactions
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic [delsu_pkg::VERT_W-1:0] first_vertex,
    input  logic [delsu_pkg::VERT_W-1:0] second_vertex,
    // result transactions
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic                         is_adjacent,
    output logic [delsu_pkg::DEG_W-1:0]  degree_count,
    output logic [delsu_pkg::VERT_W-1:0] neighbor,
    output logic                         neighbor_valid,
    output logic                         last
);

    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int IDX_W  = $clog2(MAX_EDGES);
    localparam int SEEN_W = MAX_VERTICES + 1;
    localparam int E_W    = $clog2(MAX_VERTICES + 1);
    localparam int VW     = delsu_pkg::VERT_W;
    localparam int DW     = delsu_pkg::DEG_W;

    // ---------------------------------------------------------------- state
    delsu_pkg::state_t  state_reg, state_next;
    delsu_pkg::func_t   op_reg, op_next;
    logic [VW-1:0]      u_reg, u_next;
    logic [VW-1:0]      v_reg, v_next;
    logic [VW-1:0]      vc_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   t_reg, t_next;
    logic [SEEN_W-1:0]  seen_reg, seen_next;
    logic [E_W-1:0]     e_reg, e_next;
    logic               adj_reg, adj_next;
    logic [DW-1:0]      deg_reg, deg_next;
    delsu_pkg::status_t stat_reg, stat_next;

    // output register
    logic               ov_reg, ov_next;
    logic [1:0]         ostat_reg, ostat_next;
    logic               oadj_reg, oadj_next;
    logic [DW-1:0]      odeg_reg, odeg_next;
    logic [VW-1:0]      onb_reg, onb_next;
    logic               onbv_reg, onbv_next;
    logic               olast_reg, olast_next;

    // ---------------------------------------------------------------- ring
    delsu_pkg::chain_ctrl_t ctrl;
    delsu_pkg::edge_t       in_edge;
    delsu_pkg::edge_t       head_edge;

    assign in_edge.src = first_vertex;
    assign in_edge.dst = second_vertex;

    delsu_chain #(.DEPTH(MAX_EDGES)) u_chain
    (
        .clk       (clk),
        .ctrl      (ctrl),
        .in_edge   (in_edge),
        .head_edge (head_edge)
    );

    // ---------------------------------------------------------------- helpers
    logic [VW-1:0]     n_act;       // active vertex count, capped
    logic              out_free;    // output register can take a result
    logic              in_fire;
    logic              range_bad;
    logic              store_full;
    logic              head_live;   // head cell holds a stored edge
    logic              src_hit;
    logic              dst_hit;
    logic [SEEN_W-1:0] seen_clr;

    always_comb
    begin
        if ({1'b0, vc_reg} > (VW+1)'(MAX_VERTICES))
        begin
            n_act = VW'(MAX_VERTICES);
        end
        else
        begin
            n_act = vc_reg;
        end
    end

    assign out_free   = !ov_reg || out_ready;
    assign in_fire    = in_valid && in_ready;
    assign range_bad  = (first_vertex == '0) || (first_vertex > n_act) ||
                        (second_vertex == '0) || (second_vertex > n_act);
    assign store_full = (cnt_reg == CNT_W'(MAX_EDGES));
    assign head_live  = (CNT_W'(t_reg) < cnt_reg);
    assign src_hit    = head_live && (head_edge.src == u_reg);
    assign dst_hit    = head_live && (head_edge.dst == u_reg);
    assign seen_clr   = seen_reg & ~(SEEN_W'(1) << e_reg);

    // ---------------------------------------------------------------- control
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        cnt_next   = cnt_reg;
        t_next     = t_reg;
        seen_next  = seen_reg;
        e_next     = e_reg;
        adj_next   = adj_reg;
        deg_next   = deg_reg;
        stat_next  = stat_reg;
        ctrl       = '0;
        in_ready   = 1'b0;

        // drop the held result once taken
        ov_next    = ov_reg && !out_ready;
        ostat_next = ostat_reg;
        oadj_next  = oadj_reg;
        odeg_next  = odeg_reg;
        onb_next   = onb_reg;
        onbv_next  = onbv_reg;
        olast_next = olast_reg;

        case (state_reg)
            delsu_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next   = delsu_pkg::func_t'(func);
                    u_next    = first_vertex;
                    v_next    = second_vertex;
                    adj_next  = 1'b0;
                    deg_next  = '0;
                    stat_next = delsu_pkg::STAT_OK;
                    seen_next = '0;
                    t_next    = '0;
                    e_next    = E_W'(1);
                    if (delsu_pkg::func_t'(func) == delsu_pkg::FUNC_INSERT)
                    begin
                        state_next = delsu_pkg::S_EMIT;
                        if (range_bad)
                        begin
                            stat_next = delsu_pkg::STAT_RANGE;
                        end
                        else if (store_full)
                        begin
                            stat_next = delsu_pkg::STAT_FULL;
                        end
                        else
                        begin
                            // push the new edge into cell 0
                            ctrl.shift_in = 1'b1;
                            cnt_next      = cnt_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        state_next = delsu_pkg::S_SCAN;
                    end
                end
            end

            delsu_pkg::S_SCAN:
            begin
                // one full turn of the ring brings every cell past the head
                ctrl.rotate = 1'b1;
                case (op_reg)
                    delsu_pkg::FUNC_ADJ:
                    begin
                        if (src_hit && (head_edge.dst == v_reg))
                        begin
                            adj_next = 1'b1;
                        end
                    end
                    delsu_pkg::FUNC_DEGREE:
                    begin
                        deg_next = deg_reg + DW'(src_hit) + DW'(dst_hit);
                    end
                    delsu_pkg::FUNC_LIST:
                    begin
                        if (src_hit && (head_edge.dst != '0) && (head_edge.dst <= n_act))
                        begin
                            seen_next = seen_reg | (SEEN_W'(1) << head_edge.dst);
                        end
                    end
                    default:
                    begin
                        adj_next = adj_reg;
                    end
                endcase
                t_next = t_reg + IDX_W'(1);
                if (t_reg == IDX_W'(MAX_EDGES - 1))
                begin
                    if (op_reg == delsu_pkg::FUNC_LIST)
                    begin
                        state_next = delsu_pkg::S_LIST;
                    end
                    else
                    begin
                        state_next = delsu_pkg::S_EMIT;
                    end
                end
            end

            delsu_pkg::S_LIST:
            begin
                if (seen_reg == '0)
                begin
                    // no neighbors: a single empty result
                    state_next = delsu_pkg::S_EMIT;
                end
                else if (seen_reg[e_reg])
                begin
                    if (out_free)
                    begin
                        ov_next    = 1'b1;
                        ostat_next = delsu_pkg::STAT_OK;
                        oadj_next  = 1'b0;
                        odeg_next  = '0;
                        onb_next   = VW'(e_reg);
                        onbv_next  = 1'b1;
                        olast_next = (seen_clr == '0);
                        seen_next  = seen_clr;
                        e_next     = e_reg + E_W'(1);
                        if (seen_clr == '0)
                        begin
                            state_next = delsu_pkg::S_IDLE;
                        end
                    end
                end
                else
                begin
                    e_next = e_reg + E_W'(1);
                end
            end

            delsu_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ostat_next = stat_reg;
                    oadj_next  = adj_reg;
                    odeg_next  = deg_reg;
                    onb_next   = '0;
                    onbv_next  = 1'b0;
                    olast_next = 1'b1;
                    state_next = delsu_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = delsu_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= delsu_pkg::S_IDLE;
            cnt_reg   <= '0;
            vc_reg    <= delsu_pkg::VC_RESET;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                vc_reg <= cfg_wdata;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        t_reg     <= t_next;
        seen_reg  <= seen_next;
        e_reg     <= e_next;
        adj_reg   <= adj_next;
        deg_reg   <= deg_next;
        stat_reg  <= stat_next;
        ostat_reg <= ostat_next;
        oadj_reg  <= oadj_next;
        odeg_reg  <= odeg_next;
        onb_reg   <= onb_next;
        onbv_reg  <= onbv_next;
        olast_reg <= olast_next;
    end

    assign out_valid      = ov_reg;
    assign status         = ostat_reg;
    assign is_adjacent    = oadj_reg;
    assign degree_count   = odeg_reg;
    assign neighbor       = onb_reg;
    assign neighbor_valid = onbv_reg;
    assign last           = olast_reg;

    // ---------------------------------------------------------------- checks
    `ASSERT_NEVER(a_cnt_bound, clk, rst_n, cnt_reg > CNT_W'(MAX_EDGES))
    `ASSERT_NEVER(a_ring_ctrl, clk, rst_n, ctrl.shift_in && ctrl.rotate)
    `ASSERT_CLK(a_insert_grows, clk, rst_n,
        (in_fire && (func == delsu_pkg::FUNC_INSERT) && !range_bad && !store_full)
        |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
    `ASSERT_CLK(a_nb_nonzero, clk, rst_n,
        (ov_reg && onbv_reg) |-> ((onb_reg != '0) && (ostat_reg == delsu_pkg::STAT_OK)))
    `ASSERT_CLK(a_scan_frozen_count, clk, rst_n,
        (state_reg == delsu_pkg::S_SCAN) |=> $stable(cnt_reg))

endmodule
